/* rtl/gpd_pkg.sv */
// ----------------------------------------------------------------------------
// gpd_pkg
// Shared types, constants and helper functions for the gamepad poll and
// drive mix block.
// ----------------------------------------------------------------------------
package gpd_pkg;

    typedef logic [7:0] t_byte;

    localparam int REPORT_LEN = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam int PICK_W     = 3;

    typedef logic [PICK_W-1:0] t_pick;

    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD = 1'b1;

    localparam t_pick LATERAL_PICK_RST = 3'd1;
    localparam t_pick FORWARD_PICK_RST = 3'd4;
    localparam t_pick MAX_PICK         = 3'd4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BIT   = 1'b1;

    localparam logic [2:0] BIT_LAST     = 3'd7;
    localparam logic [3:0] BYTE_IDENT   = 4'd1;
    localparam logic [3:0] BYTE_CHECK   = 4'd2;
    localparam logic [3:0] REPORT_FIRST = 4'd3;
    localparam logic [3:0] LAST_BYTE    = 4'd8;

    localparam t_byte CMD_START  = 8'h01;
    localparam t_byte CMD_POLL   = 8'h42;
    localparam t_byte CMD_IDLE   = 8'h00;
    localparam t_byte IDENT_HI   = 8'h73;
    localparam t_byte IDENT_LO   = 8'h5A;
    localparam t_byte LAT_CENTER = 8'h80;
    localparam t_byte FWD_CENTER = 8'h7F;
    localparam t_byte DRIVE_BASE = 8'hBB;
    localparam t_byte DRIVE_MAX  = 8'hFF;

    typedef t_byte t_report [REPORT_LEN];

    localparam t_report REPORT_DEFAULTS = '{8'hFF, 8'hFF, 8'h80, 8'h7F, 8'h80, 8'h7F};

    typedef struct packed {
        logic req_type;
        logic dat_bit;
    } t_in_item;

    typedef struct packed {
        logic        cmd_bit;
        logic        select_active;
        logic        frame_done;
        logic        link_ok;
        logic [15:0] buttons;
        t_byte       motor_a;
        t_byte       motor_b;
        t_byte       motor_c;
        t_byte       motor_d;
    } t_out_item;

    typedef struct packed {
        logic        cmd_bit;
        logic        select_active;
        logic        frame_done;
        logic        link_ok;
        logic [15:0] buttons;
        t_byte       lat_axis;
        t_byte       fwd_axis;
    } t_frame_view;

    typedef struct packed {
        t_byte motor_a;
        t_byte motor_b;
        t_byte motor_c;
        t_byte motor_d;
    } t_drive;

    function automatic t_byte cmd_byte(input logic [3:0] pos);
        t_byte b;
        if (pos == 4'd0) begin
            b = CMD_START;
        end else if (pos == 4'd1) begin
            b = CMD_POLL;
        end else begin
            b = CMD_IDLE;
        end
        return b;
    endfunction

endpackage

/* rtl/gpd_frame.sv */
// ----------------------------------------------------------------------------
// gpd_frame
// Poll frame sequencer: bit and byte counters, receive shifter, link check
// and the stored report bytes. Presents the post-transaction view.
// ----------------------------------------------------------------------------
module gpd_frame
    import gpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  t_pick       i_lat_pick,
    input  t_pick       i_fwd_pick,
    output t_frame_view o_view
);

    logic       r_busy, n_busy;
    logic [3:0] r_byte, n_byte;
    logic [2:0] r_bit, n_bit;
    t_byte      r_shift, n_shift;
    t_byte      r_ident, n_ident;
    t_report    r_rep, n_rep;
    t_byte      shift_or;
    logic       end_frame;
    logic       n_done, n_link;
    t_byte      cmd_cur;

    function automatic t_byte axis_sel(input t_pick pick, input t_report rep);
        t_byte b;
        case (pick)
            3'd0:    b = rep[1];
            3'd1:    b = rep[2];
            3'd2:    b = rep[3];
            3'd3:    b = rep[4];
            default: b = rep[5];
        endcase
        return b;
    endfunction

    assign shift_or = r_shift | (t_byte'(i_item.dat_bit) << r_bit);

    always_comb begin
        n_busy    = r_busy;
        n_byte    = r_byte;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_ident   = r_ident;
        n_rep     = r_rep;
        n_done    = 1'b0;
        n_link    = 1'b0;
        end_frame = 1'b0;
        if (i_accept) begin
            if (i_item.req_type == REQ_START) begin
                n_busy  = 1'b1;
                n_byte  = '0;
                n_bit   = '0;
                n_shift = '0;
            end else if (r_busy) begin
                if (r_bit == BIT_LAST) begin
                    n_shift = '0;
                    n_bit   = '0;
                    if (r_byte == BYTE_IDENT) begin
                        n_ident = shift_or;
                    end else if (r_byte == BYTE_CHECK) begin
                        if (!(r_ident == IDENT_HI && shift_or == IDENT_LO)) begin
                            n_rep     = REPORT_DEFAULTS;
                            end_frame = 1'b1;
                        end
                    end else if (r_byte >= REPORT_FIRST && r_byte <= LAST_BYTE) begin
                        n_rep[3'(r_byte - REPORT_FIRST)] = shift_or;
                        if (r_byte == LAST_BYTE) begin
                            end_frame = 1'b1;
                            n_link    = 1'b1;
                        end
                    end else if (r_byte > LAST_BYTE) begin
                        end_frame = 1'b1;
                    end
                    if (end_frame) begin
                        n_busy = 1'b0;
                        n_byte = '0;
                        n_done = 1'b1;
                    end else begin
                        n_byte = r_byte + 4'd1;
                    end
                end else begin
                    n_bit   = r_bit + 3'd1;
                    n_shift = shift_or;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_byte  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_ident <= '0;
            r_rep   <= REPORT_DEFAULTS;
        end else begin
            r_busy  <= n_busy;
            r_byte  <= n_byte;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_ident <= n_ident;
            r_rep   <= n_rep;
        end
    end

    assign cmd_cur = cmd_byte(n_byte);

    always_comb begin
        o_view.cmd_bit       = n_busy & cmd_cur[n_bit];
        o_view.select_active = n_busy;
        o_view.frame_done    = n_done;
        o_view.link_ok       = n_link;
        o_view.buttons       = {n_rep[0], n_rep[1]};
        o_view.lat_axis      = axis_sel(i_lat_pick, n_rep);
        o_view.fwd_axis      = axis_sel(i_fwd_pick, n_rep);
    end

endmodule

/* rtl/gpd_mix.sv */
// ----------------------------------------------------------------------------
// gpd_mix
// Motor drive mixer: splits both axes around their centers, sums the halves
// in pairs and maps each sum onto the saturated drive range.
// ----------------------------------------------------------------------------
module gpd_mix
    import gpd_pkg::*;
(
    input  t_byte  i_lat_axis,
    input  t_byte  i_fwd_axis,
    output t_drive o_drive
);

    logic [8:0] px, nx, py, ny;

    function automatic t_byte drive_cap(input logic [9:0] v);
        logic [8:0] t;
        t_byte      r;
        t = 9'(v >> 2) + 9'(DRIVE_BASE);
        if (v == '0) begin
            r = '0;
        end else if (t > 9'(DRIVE_MAX)) begin
            r = DRIVE_MAX;
        end else begin
            r = t[7:0];
        end
        return r;
    endfunction

    always_comb begin
        px = (i_lat_axis > LAT_CENTER) ? {1'b0, i_lat_axis - LAT_CENTER} << 1 : '0;
        nx = (i_lat_axis < LAT_CENTER) ? {1'b0, LAT_CENTER - i_lat_axis} << 1 : '0;
        py = (i_fwd_axis > FWD_CENTER) ? {1'b0, i_fwd_axis - FWD_CENTER} << 1 : '0;
        ny = (i_fwd_axis < FWD_CENTER) ? {1'b0, FWD_CENTER - i_fwd_axis} << 1 : '0;
        o_drive.motor_a = drive_cap({1'b0, px} + {1'b0, py});
        o_drive.motor_b = drive_cap({1'b0, nx} + {1'b0, ny});
        o_drive.motor_c = drive_cap({1'b0, nx} + {1'b0, py});
        o_drive.motor_d = drive_cap({1'b0, px} + {1'b0, ny});
    end

endmodule

/* rtl/gamepad_poll_and_drive_mix.sv */
// ----------------------------------------------------------------------------
// gamepad_poll_and_drive_mix
// Gamepad poll sequencer with motor drive mixing, one bit period per
// transaction.
// ----------------------------------------------------------------------------
// Each input transaction is either a frame start or one serial bit period.
// The block takes one transaction per clock and registers exactly one result
// transaction for it in a single output register; a
// stall on the output holds that register and stalls the input in turn.
// The two axis pick registers are written through the configuration port
// and must only change while no transaction is in flight.
module gamepad_poll_and_drive_mix
    import gpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_pick       r_lat_pick, r_fwd_pick;
    t_pick       lat_sat, fwd_sat;
    logic        in_accept;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data, n_out_data;
    t_frame_view view;
    t_drive      drive;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_pick <= LATERAL_PICK_RST;
            r_fwd_pick <= FORWARD_PICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LATERAL: r_lat_pick <= i_cfg_data;
                CFG_FORWARD: r_fwd_pick <= i_cfg_data;
                default:     r_lat_pick <= r_lat_pick;
            endcase
        end
    end

    assign lat_sat = (r_lat_pick > MAX_PICK) ? MAX_PICK : r_lat_pick;
    assign fwd_sat = (r_fwd_pick > MAX_PICK) ? MAX_PICK : r_fwd_pick;

    gpd_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_in_data),
        .i_lat_pick (lat_sat),
        .i_fwd_pick (fwd_sat),
        .o_view     (view)
    );

    gpd_mix u_mix (
        .i_lat_axis (view.lat_axis),
        .i_fwd_axis (view.fwd_axis),
        .o_drive    (drive)
    );

    always_comb begin
        n_out_valid = in_accept | (r_out_valid & i_out_stall);
        n_out_data  = r_out_data;
        if (in_accept) begin
            n_out_data.cmd_bit       = view.cmd_bit;
            n_out_data.select_active = view.select_active;
            n_out_data.frame_done    = view.frame_done;
            n_out_data.link_ok       = view.link_ok;
            n_out_data.buttons       = view.buttons;
            n_out_data.motor_a       = drive.motor_a;
            n_out_data.motor_b       = drive.motor_b;
            n_out_data.motor_c       = drive.motor_c;
            n_out_data.motor_d       = drive.motor_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/gpd_checker.sv */
// ----------------------------------------------------------------------------
// gpd_checker
// Port-level checks for the gamepad poll and drive mix block, bound to the
// top level.
// ----------------------------------------------------------------------------
module gpd_checker
    import gpd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input t_out_item             o_out_data,
    input logic                  i_out_stall
);

    // A completed frame always leaves the device deselected.
    a_done_deselects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |-> !o_out_data.select_active)
        else $error("frame_done reported while select_active is high");

    // Link status is only reported on the transaction that ends a frame.
    a_link_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.link_ok |-> o_out_data.frame_done)
        else $error("link_ok reported outside a completing transaction");

    // The command line idles low whenever the device is not selected.
    a_cmd_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.select_active |-> !o_out_data.cmd_bit)
        else $error("cmd_bit high while no frame is active");

    // A stalled result stays presented and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed or dropped");

endmodule

bind gamepad_poll_and_drive_mix gpd_checker u_gpd_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the gamepad poll and drive mix block.
// ----------------------------------------------------------------------------
// The testbench polls the block with directed and random serial frames. It
// covers good frames, bad identification, aborted frames and idle bits.
// Random sender gaps, receiver stalls and one long receiver hold-off run
// alongside the frames. A behavioral copy of the poll sequencer and the motor
// mixer predicts every result transaction. The checker compares each result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import gpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    t_in_item              in_data;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  out_stall;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted state of the poll sequencer.
    logic       frame_open;
    logic [3:0] byte_idx;
    logic [2:0] bit_idx;
    t_byte      rx_shift;
    t_byte      ident_seen;
    t_report    report;
    t_pick      lat_pick;
    t_pick      fwd_pick;

    t_out_item  pending_reports[$];
    int         fail_count;
    int         result_count;
    int         idle_cycles;
    int         work_items;
    int         burst_left;
    bit         tx_bursty;
    bit         rx_quiet;
    int         hold_left;
    int         rx_run;
    bit         rx_stalling;

    gamepad_poll_and_drive_mix dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic t_byte drive_level(input int v);
        int d;
        d = v;
        if (d > 0) begin
            d = d / 4 + int'(DRIVE_BASE);
        end
        return (d > 255) ? DRIVE_MAX : t_byte'(d);
    endfunction

    function automatic t_out_item poll_step(input t_in_item it);
        t_out_item r;
        t_byte     b;
        t_byte     cmd;
        int        x;
        int        y;
        int        px;
        int        nx;
        int        py;
        int        ny;
        logic      fin;
        r   = '0;
        fin = 1'b0;
        if (it.req_type == REQ_START) begin
            frame_open = 1'b1;
            byte_idx   = '0;
            bit_idx    = '0;
            rx_shift   = '0;
        end else if (frame_open) begin
            rx_shift = rx_shift | (t_byte'(it.dat_bit) << bit_idx);
            if (bit_idx == BIT_LAST) begin
                b        = rx_shift;
                rx_shift = '0;
                bit_idx  = '0;
                if (byte_idx == BYTE_IDENT) begin
                    ident_seen = b;
                end else if (byte_idx == BYTE_CHECK) begin
                    if (!(ident_seen == IDENT_HI && b == IDENT_LO)) begin
                        report = REPORT_DEFAULTS;
                        fin    = 1'b1;
                    end
                end else if (byte_idx >= REPORT_FIRST && byte_idx <= LAST_BYTE) begin
                    report[int'(byte_idx) - int'(REPORT_FIRST)] = b;
                    if (byte_idx == LAST_BYTE) begin
                        fin       = 1'b1;
                        r.link_ok = 1'b1;
                    end
                end else if (byte_idx > LAST_BYTE) begin
                    fin = 1'b1;
                end
                if (fin) begin
                    frame_open   = 1'b0;
                    byte_idx     = '0;
                    r.frame_done = 1'b1;
                end else begin
                    byte_idx = byte_idx + 4'd1;
                end
            end else begin
                bit_idx = bit_idx + 3'd1;
            end
        end

        x  = int'(report[1 + ((lat_pick > MAX_PICK) ? int'(MAX_PICK) : int'(lat_pick))]);
        y  = int'(report[1 + ((fwd_pick > MAX_PICK) ? int'(MAX_PICK) : int'(fwd_pick))]);
        px = (x > int'(LAT_CENTER)) ? (x - int'(LAT_CENTER)) * 2 : 0;
        nx = (x < int'(LAT_CENTER)) ? (int'(LAT_CENTER) - x) * 2 : 0;
        py = (y > int'(FWD_CENTER)) ? (y - int'(FWD_CENTER)) * 2 : 0;
        ny = (y < int'(FWD_CENTER)) ? (int'(FWD_CENTER) - y) * 2 : 0;

        case (byte_idx)
            4'd0:    cmd = CMD_START;
            4'd1:    cmd = CMD_POLL;
            default: cmd = CMD_IDLE;
        endcase
        r.cmd_bit       = frame_open ? cmd[bit_idx] : 1'b0;
        r.select_active = frame_open;
        r.buttons       = {report[0], report[1]};
        r.motor_a       = drive_level(px + py);
        r.motor_b       = drive_level(nx + ny);
        r.motor_c       = drive_level(nx + py);
        r.motor_d       = drive_level(px + ny);
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch at result %0d: %s", result_count, msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            note_failure($sformatf("%s expected %h, got %h", name, want, got));
        end
    endfunction

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_idx == CFG_LATERAL) begin
                    lat_pick = cfg_data;
                end else if (cfg_idx == CFG_FORWARD) begin
                    fwd_pick = cfg_data;
                end
            end
            if (in_valid && in_stall === 1'b0) begin
                pending_reports.push_back(poll_step(in_data));
            end
            if (out_valid === 1'b1 && !out_stall) begin
                if (pending_reports.size() == 0) begin
                    note_failure("result transaction with no prediction waiting");
                end else begin
                    want = pending_reports.pop_front();
                    check_field("cmd_bit", 16'(want.cmd_bit), 16'(out_data.cmd_bit));
                    check_field("select_active", 16'(want.select_active),
                                16'(out_data.select_active));
                    check_field("frame_done", 16'(want.frame_done),
                                16'(out_data.frame_done));
                    check_field("link_ok", 16'(want.link_ok), 16'(out_data.link_ok));
                    check_field("buttons", want.buttons, out_data.buttons);
                    check_field("motor_a", 16'(want.motor_a), 16'(out_data.motor_a));
                    check_field("motor_b", 16'(want.motor_b), 16'(out_data.motor_b));
                    check_field("motor_c", 16'(want.motor_c), 16'(out_data.motor_c));
                    check_field("motor_d", 16'(want.motor_d), 16'(out_data.motor_d));
                end
                result_count++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        out_stall   = 1'b0;
        rx_run      = 0;
        rx_stalling = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (rx_quiet) begin
                out_stall = 1'b0;
            end else begin
                if (rx_run == 0) begin
                    rx_stalling = ($urandom_range(0, 2) == 0);
                    rx_run      = rx_stalling ? $urandom_range(1, 5) : $urandom_range(1, 12);
                end
                rx_run--;
                out_stall = rx_stalling;
            end
        end
    end

    task automatic send_item(input logic req, input logic dat);
        int gap;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(0, 10);
                burst_left = $urandom_range(1, 20);
                if (gap > 0) begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
        end
        if (req == REQ_START || frame_open) begin
            work_items++;
        end
        in_valid         = 1'b1;
        in_data.req_type = req;
        in_data.dat_bit  = dat;
        do @(posedge clk); while (in_stall !== 1'b0);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input t_pick val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_picks(input t_pick lat, input t_pick fwd);
        wait_drained();
        write_cfg(CFG_LATERAL, lat);
        write_cfg(CFG_FORWARD, fwd);
    endtask

    function automatic t_byte some_byte();
        t_byte b;
        case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = LAT_CENTER;
            3:       b = FWD_CENTER;
            default: b = t_byte'($urandom);
        endcase
        return b;
    endfunction

    function automatic t_report some_report();
        t_report rep;
        for (int k = 0; k < REPORT_LEN; k++) begin
            rep[k] = some_byte();
        end
        return rep;
    endfunction

    // Sends a start and then the first nbits bits of the frame, LSB first.
    task automatic send_frame(input t_byte id, input t_byte chk, input t_report rep,
                              input int nbits);
        logic [71:0] stream;
        stream = {rep[5], rep[4], rep[3], rep[2], rep[1], rep[0], chk, id,
                  t_byte'($urandom)};
        send_item(REQ_START, 1'($urandom));
        for (int i = 0; i < nbits; i++) begin
            send_item(REQ_BIT, stream[i]);
        end
    endtask

    task automatic test_idle_and_restart();
        send_item(REQ_BIT, 1'b1);
        send_item(REQ_BIT, 1'b0);
        send_item(REQ_START, 1'b1);
        send_item(REQ_BIT, 1'b1);
        send_item(REQ_BIT, 1'b0);
        send_item(REQ_BIT, 1'b1);
        send_frame(IDENT_HI, IDENT_LO ^ 8'h01, some_report(), 24);
        wait_drained();
    endtask

    task automatic test_axis_picks();
        t_pick   lats [7] = '{3'd0, 3'd4, 3'd7, 3'd0, 3'd7, 3'd1, 3'd2};
        t_pick   fwds [7] = '{3'd0, 3'd4, 3'd7, 3'd7, 3'd0, 3'd4, 3'd3};
        t_report rep;
        for (int s = 0; s < 7; s++) begin
            set_picks(lats[s], fwds[s]);
            if (s == 0) begin
                rep = '{default: 8'h00};
            end else if (s == 1) begin
                rep = '{default: 8'hFF};
            end else if (s == 2) begin
                rep = '{LAT_CENTER, FWD_CENTER, LAT_CENTER, FWD_CENTER, LAT_CENTER,
                        FWD_CENTER};
            end else begin
                rep = some_report();
            end
            send_frame(IDENT_HI, IDENT_LO, rep, 72);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_bursty = 1'b0;
        rx_quiet  = 1'b0;
        hold_left = HOLD_CYCLES;
        send_frame(IDENT_HI, IDENT_LO, some_report(), 72);
        wait_drained();
        tx_bursty = 1'b1;
        send_frame(IDENT_HI, IDENT_LO, some_report(), 72);
        wait_drained();
    endtask

    task automatic test_random_polls(input int target);
        int    frames;
        int    kind;
        t_byte id;
        t_byte chk;
        frames = 0;
        while (work_items < target) begin
            frames++;
            if (frames % 8 == 0) begin
                set_picks(t_pick'($urandom_range(0, 7)), t_pick'($urandom_range(0, 7)));
            end
            if (frames % 5 == 0) begin
                tx_bursty = ($urandom_range(0, 3) != 0);
                rx_quiet  = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 19);
            if (kind < 13) begin
                send_frame(IDENT_HI, IDENT_LO, some_report(), 72);
            end else if (kind < 16) begin
                case ($urandom_range(0, 2))
                    0: begin
                        id  = t_byte'($urandom);
                        chk = t_byte'($urandom);
                    end
                    1: begin
                        id  = IDENT_HI;
                        chk = IDENT_LO ^ (8'h01 << $urandom_range(0, 7));
                    end
                    default: begin
                        id  = IDENT_HI ^ (8'h01 << $urandom_range(0, 7));
                        chk = IDENT_LO;
                    end
                endcase
                send_frame(id, chk, some_report(), $urandom_range(24, 30));
            end else begin
                send_frame(IDENT_HI, IDENT_LO, some_report(), $urandom_range(0, 71));
            end
        end
        wait_drained();
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        frame_open   = 1'b0;
        byte_idx     = '0;
        bit_idx      = '0;
        rx_shift     = '0;
        ident_seen   = '0;
        report       = REPORT_DEFAULTS;
        lat_pick     = LATERAL_PICK_RST;
        fwd_pick     = FORWARD_PICK_RST;
        fail_count   = 0;
        result_count = 0;
        idle_cycles  = 0;
        work_items   = 0;
        burst_left   = 0;
        tx_bursty    = 1'b1;
        rx_quiet     = 1'b0;
        hold_left    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_and_restart();
        test_axis_picks();
        test_backpressure();
        test_random_polls(1350);

        wait_drained();
        repeat (5) @(negedge clk);
        if (pending_reports.size() != 0) begin
            note_failure($sformatf("%0d predictions left over", pending_reports.size()));
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/gpd_pkg.sv
rtl/gpd_frame.sv
rtl/gpd_mix.sv
rtl/gamepad_poll_and_drive_mix.sv
rtl/gpd_checker.sv
test/tb_top.sv
